>>> rtl/rpu_pkg.sv
// Shared types and constants for the RMSProp parameter update unit.
// Depends on nothing; every other file in rtl/ but rpu_ram.sv imports it.
package rpu_pkg;

  // Store depths.
  localparam int WEIGHT_COUNT = 4096;
  localparam int BIAS_COUNT   = 256;
  localparam int W_AW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam int B_AW = (BIAS_COUNT > 1) ? $clog2(BIAS_COUNT) : 1;

  // The clearing pass after reset covers the deeper store.
  localparam int CLR_COUNT = (WEIGHT_COUNT > BIAS_COUNT) ? WEIGHT_COUNT : BIAS_COUNT;
  localparam int CLR_W     = (CLR_COUNT > 1) ? $clog2(CLR_COUNT) : 1;

  // Field and datapath widths.
  localparam int IDX_W   = 12;
  localparam int DATA_W  = 32;
  localparam int DECAY_W = 16;
  localparam int CFG_W   = 25;
  localparam int BATCH_W = 16;
  localparam int FRAC_W  = 24;
  localparam int GSQ_W   = 2 * DATA_W;
  localparam int NUM_W   = CFG_W + DATA_W;
  localparam int PRE_W   = DECAY_W + 1 + DATA_W;
  localparam int ACC_W   = PRE_W + 1;
  localparam int SE_W    = DATA_W + 1;
  localparam int RAD_W   = 2 * ((SE_W + FRAC_W + 1) / 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int DEN_W   = BATCH_W + ROOT_W;
  localparam int Q_W     = DATA_W + 2;
  localparam int PDIV_W  = DEN_W + Q_W;

  // Unity in the Q0.16 decay format.
  localparam logic [DECAY_W:0] ONE_Q16 = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DECAY         = 2'd0,
    CFG_EPSILON       = 2'd1,
    CFG_LEARNING_RATE = 2'd2,
    CFG_BATCH_SIZE    = 2'd3
  } cfg_index_t;

  // Side information that travels with a request through the long pipes.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     neg;
    logic                     in_range;
    logic                     ovf;
    logic signed [DATA_W-1:0] p;
    logic [NUM_W-1:0]         num;
  } tag_t;

endpackage

>>> rtl/rmsprop_parameter_update_unit.sv
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken (in_ready follows out_ready).
// Reset: synchronous; after reset a clearing pass zeroes both
// square stores, and in_ready stays low until it ends. Configuration writes
// are taken at any time (cfg_ready is always high).
module rmsprop_parameter_update_unit import rpu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     store_select,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] param_value,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic                     last_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] new_param,
  output logic                     last_out,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  typedef struct packed {
    logic                     valid;
    logic                     sel;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     neg;
    logic                     last;
    logic signed [DATA_W-1:0] p;
    logic [DATA_W-1:0]        mag;
  } front_t;

  typedef struct packed {
    logic                     valid;
    logic                     sel;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     neg;
    logic                     last;
    logic signed [DATA_W-1:0] p;
    logic [GSQ_W-1:0]         gsq_full;
    logic [NUM_W-1:0]         num;
  } prod_t;

  typedef struct packed {
    logic                     valid;
    logic                     sel;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     neg;
    logic                     last;
    logic signed [DATA_W-1:0] p;
    logic [NUM_W-1:0]         num;
    logic [PRE_W-1:0]         pre;
  } upd_t;

  // Configuration registers.
  logic [DECAY_W-1:0] decay;
  logic [CFG_W-1:0]   epsilon;
  logic [CFG_W-1:0]   learning_rate;
  logic [BATCH_W-1:0] batch_size;

  // Clearing pass state.
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  // Pipeline registers.
  front_t           s1;
  prod_t            s2;
  upd_t             s3;
  tag_t             s4_tag;
  logic [SE_W-1:0]  s4_se;
  tag_t             sq_tag;
  logic [ROOT_W-1:0] sq_root;
  tag_t             dn_tag;
  logic [DEN_W-1:0] dn_den;
  tag_t             ov_tag;
  logic [DEN_W-1:0] ov_den;
  tag_t             dv_tag;
  logic [Q_W-1:0]   dv_q;

  // Most recent store write, forwarded to the read that just missed it.
  logic              lw_valid;
  logic              lw_sel;
  logic [IDX_W-1:0]  lw_idx;
  logic [DATA_W-1:0] lw_data;

  logic              adv;
  logic              upd_we;
  logic [DATA_W-1:0] w_rdata;
  logic [DATA_W-1:0] b_rdata;
  logic [DATA_W-1:0] s_old;
  logic [DATA_W-1:0] s_new;
  logic [ACC_W-1:0]  acc;
  logic [DATA_W-1:0] gsq;
  logic [GSQ_W-1:0]  gsq_full_c;
  logic [NUM_W-1:0]  num_c;
  logic [PRE_W-1:0]  pre_c;
  logic [2*DATA_W-2+DECAY_W-DATA_W+1:0] decay_prod;
  logic              in_range_c;
  logic [ROOT_W-1:0] root_eff;
  logic [BATCH_W-1:0] batch_eff;
  logic [DEN_W-1:0]  den_c;
  logic [Q_W-1:0]    q_eff;
  logic signed [Q_W+1:0] res;

  // The whole pipeline advances unless a result is waiting at the output.
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !clearing;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      decay         <= 16'd58982;
      epsilon       <= 25'd1;
      learning_rate <= 25'd16777;
      batch_size    <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DECAY:         decay         <= cfg_data[DECAY_W-1:0];
        CFG_EPSILON:       epsilon       <= cfg_data;
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        CFG_BATCH_SIZE:    batch_size    <= cfg_data[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass over both stores after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(CLR_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Stage 1: capture the request, take the gradient magnitude.
  assign in_range_c = store_select ? (32'(element_index) < 32'(BIAS_COUNT))
                                   : (32'(element_index) < 32'(WEIGHT_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (adv) begin
      s1.valid    <= in_valid && in_ready;
      s1.sel      <= store_select;
      s1.idx      <= element_index;
      s1.in_range <= in_range_c;
      s1.neg      <= gradient[DATA_W-1];
      s1.last     <= last_in;
      s1.p        <= param_value;
      s1.mag      <= gradient[DATA_W-1] ? DATA_W'(-gradient) : DATA_W'(gradient);
    end
  end

  // Stage 2: gradient square and learning rate times magnitude.
  assign gsq_full_c = s1.mag * s1.mag;
  assign num_c      = learning_rate * s1.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2.valid    <= s1.valid;
      s2.sel      <= s1.sel;
      s2.idx      <= s1.idx;
      s2.in_range <= s1.in_range;
      s2.neg      <= s1.neg;
      s2.last     <= s1.last;
      s2.p        <= s1.p;
      s2.gsq_full <= gsq_full_c;
      s2.num      <= num_c;
    end
  end

  // Stage 3: saturate the square to Q8.24 and weight it by one minus decay.
  assign gsq   = (|s2.gsq_full[GSQ_W-1:DATA_W+FRAC_W]) ? '1
                 : s2.gsq_full[DATA_W+FRAC_W-1:FRAC_W];
  assign pre_c = (ONE_Q16 - (DECAY_W+1)'(decay)) * gsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (adv) begin
      s3.valid    <= s2.valid;
      s3.sel      <= s2.sel;
      s3.idx      <= s2.idx;
      s3.in_range <= s2.in_range;
      s3.neg      <= s2.neg;
      s3.last     <= s2.last;
      s3.p        <= s2.p;
      s3.num      <= s2.num;
      s3.pre      <= pre_c;
    end
  end

  // Square stores; read issued from stage 2, data lines up with stage 3.
  assign upd_we = adv && s3.valid && s3.in_range;

  rpu_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_COUNT)) u_weight_ram (
    .clk   (clk),
    .we    (clearing || (upd_we && !s3.sel)),
    .waddr (clearing ? W_AW'(clr_cnt) : W_AW'(s3.idx)),
    .wdata (clearing ? '0 : s_new),
    .re    (adv),
    .raddr (W_AW'(s2.idx)),
    .rdata (w_rdata)
  );

  rpu_ram #(.WIDTH(DATA_W), .DEPTH(BIAS_COUNT)) u_bias_ram (
    .clk   (clk),
    .we    (clearing || (upd_we && s3.sel)),
    .waddr (clearing ? B_AW'(clr_cnt) : B_AW'(s3.idx)),
    .wdata (clearing ? '0 : s_new),
    .re    (adv),
    .raddr (B_AW'(s2.idx)),
    .rdata (b_rdata)
  );

  // Running mean update with forwarding from the write that just happened.
  assign s_old = (lw_valid && lw_sel == s3.sel && lw_idx == s3.idx) ? lw_data
                 : (s3.sel ? b_rdata : w_rdata);
  assign decay_prod = decay * s_old;
  assign acc   = ACC_W'(decay_prod) + ACC_W'(s3.pre);
  assign s_new = (|acc[ACC_W-1:DATA_W+DECAY_W]) ? '1 : acc[DATA_W+DECAY_W-1:DECAY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (upd_we) begin
      lw_valid <= 1'b1;
      lw_sel   <= s3.sel;
      lw_idx   <= s3.idx;
      lw_data  <= s_new;
    end
  end

  // Stage 4: add epsilon ahead of the square root.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_tag.valid <= 1'b0;
    end else if (adv) begin
      s4_tag.valid    <= s3.valid;
      s4_tag.last     <= s3.last;
      s4_tag.neg      <= s3.neg;
      s4_tag.in_range <= s3.in_range;
      s4_tag.ovf      <= 1'b0;
      s4_tag.p        <= s3.p;
      s4_tag.num      <= s3.num;
      s4_se           <= SE_W'(s_new) + SE_W'(epsilon);
    end
  end

  rpu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_tag   (s4_tag),
    .in_rad   (RAD_W'({s4_se, {FRAC_W{1'b0}}})),
    .out_tag  (sq_tag),
    .out_root (sq_root)
  );

  // Divisor: batch size times root, both forced to at least one.
  assign root_eff  = (sq_root == '0) ? ROOT_W'(1) : sq_root;
  assign batch_eff = (batch_size == '0) ? BATCH_W'(1) : batch_size;
  assign den_c     = batch_eff * root_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_tag.valid <= 1'b0;
    end else if (adv) begin
      dn_tag <= sq_tag;
      dn_den <= den_c;
    end
  end

  // Flag quotients too large for the divider; they saturate the result anyway.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov_tag.valid <= 1'b0;
    end else if (adv) begin
      ov_tag.valid    <= dn_tag.valid;
      ov_tag.last     <= dn_tag.last;
      ov_tag.neg      <= dn_tag.neg;
      ov_tag.in_range <= dn_tag.in_range;
      ov_tag.ovf      <= DEN_W'(dn_tag.num[NUM_W-1:Q_W]) >= dn_den;
      ov_tag.p        <= dn_tag.p;
      ov_tag.num      <= dn_tag.num;
      ov_den          <= dn_den;
    end
  end

  rpu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_tag  (ov_tag),
    .in_den  (ov_den),
    .out_tag (dv_tag),
    .out_q   (dv_q)
  );

  // Output stage: apply the step, saturate to 32 bits; out of range keeps p.
  assign q_eff = dv_tag.ovf ? '1 : dv_q;
  assign res   = dv_tag.neg ? ((Q_W+2)'(dv_tag.p) + $signed({2'b00, q_eff}))
                            : ((Q_W+2)'(dv_tag.p) - $signed({2'b00, q_eff}));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_tag.valid;
      last_out  <= dv_tag.last;
      if (!dv_tag.in_range) begin
        new_param <= dv_tag.p;
      end else if (res > (Q_W+2)'(signed'(32'sh7FFFFFFF))) begin
        new_param <= 32'sh7FFFFFFF;
      end else if (res < (Q_W+2)'(signed'(32'sh80000000))) begin
        new_param <= 32'sh80000000;
      end else begin
        new_param <= DATA_W'(res);
      end
    end
  end

endmodule

>>> rtl/rpu_ram.sv
// Generic single write port RAM with a registered, enabled read port.
// No dependencies.
module rpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then registered read (read during write returns old data).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rpu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rpu_pkg for widths and the tag type.
module rpu_sqrt import rpu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tag_t              in_tag,
  input  logic [RAD_W-1:0]  in_rad,
  output tag_t              out_tag,
  output logic [ROOT_W-1:0] out_root
);

  tag_t              tag_q  [ROOT_W];
  logic [RAD_W-1:0]  x_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  tag_t              tag_n  [ROOT_W];
  logic [RAD_W-1:0]  x_n    [ROOT_W];
  logic [REM_W-1:0]  rem_n  [ROOT_W];
  logic [ROOT_W-1:0] root_n [ROOT_W];

  // Each stage brings down two radicand bits and decides one root bit.
  always_comb begin
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  x_in;
    for (int i = 0; i < ROOT_W; i++) begin
      if (i == 0) begin
        rem_in    = '0;
        root_in   = '0;
        x_in      = in_rad;
        tag_n[i]  = in_tag;
      end else begin
        rem_in    = rem_q[i-1];
        root_in   = root_q[i-1];
        x_in      = x_q[i-1];
        tag_n[i]  = tag_q[i-1];
      end
      rem_sh = {rem_in[REM_W-3:0], x_in[RAD_W-1 -: 2]};
      trial  = REM_W'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_n[i]  = rem_sh - trial;
        root_n[i] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n[i]  = rem_sh;
        root_n[i] = {root_in[ROOT_W-2:0], 1'b0};
      end
      x_n[i] = x_in << 2;
    end
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROOT_W; i++) begin
        tag_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < ROOT_W; i++) begin
        tag_q[i]  <= tag_n[i];
        x_q[i]    <= x_n[i];
        rem_q[i]  <= rem_n[i];
        root_q[i] <= root_n[i];
      end
    end
  end

  assign out_tag  = tag_q[ROOT_W-1];
  assign out_root = root_q[ROOT_W-1];

endmodule

>>> rtl/rpu_div.sv
// Pipelined restoring divider, one quotient bit per stage, dividend from the tag.
// Depends on rpu_pkg for widths and the tag type.
module rpu_div import rpu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  tag_t             in_tag,
  input  logic [DEN_W-1:0] in_den,
  output tag_t             out_tag,
  output logic [Q_W-1:0]   out_q
);

  tag_t             tag_q [Q_W];
  logic [NUM_W-1:0] r_q   [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  tag_t             tag_n [Q_W];
  logic [NUM_W-1:0] r_n   [Q_W];
  logic [DEN_W-1:0] den_n [Q_W];
  logic [Q_W-1:0]   quo_n [Q_W];

  // Stage i tries the shifted divisor for quotient bit Q_W-1-i.
  always_comb begin
    logic [NUM_W-1:0]  r_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_W-1:0]    quo_in;
    logic [PDIV_W-1:0] dsh;
    logic              ge;
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        r_in     = in_tag.num;
        den_in   = in_den;
        quo_in   = '0;
        tag_n[i] = in_tag;
      end else begin
        r_in     = r_q[i-1];
        den_in   = den_q[i-1];
        quo_in   = quo_q[i-1];
        tag_n[i] = tag_q[i-1];
      end
      dsh      = PDIV_W'(den_in) << (Q_W - 1 - i);
      ge       = (PDIV_W'(r_in) >= dsh);
      r_n[i]   = ge ? NUM_W'(PDIV_W'(r_in) - dsh) : r_in;
      den_n[i] = den_in;
      quo_n[i] = {quo_in[Q_W-2:0], ge};
    end
  end

  // Stage registers; only the valid bits are reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_W; i++) begin
        tag_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < Q_W; i++) begin
        tag_q[i] <= tag_n[i];
        r_q[i]   <= r_n[i];
        den_q[i] <= den_n[i];
        quo_q[i] <= quo_n[i];
      end
    end
  end

  assign out_tag = tag_q[Q_W-1];
  assign out_q   = quo_q[Q_W-1];

endmodule

>>> rtl/rpu_checker.sv
// Port-level checks for the RMSProp parameter update unit, bound to the top level.
// Depends on rpu_pkg and on the top level's port list.
module rpu_port_checks import rpu_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     store_select,
  input logic [IDX_W-1:0]         element_index,
  input logic signed [DATA_W-1:0] param_value,
  input logic signed [DATA_W-1:0] gradient,
  input logic                     last_in,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] new_param,
  input logic                     last_out,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [1:0]               cfg_index,
  input logic [CFG_W-1:0]         cfg_data
);

  // Reset empties the output and starts the clearing pass.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

  // A stalled output holds the pipeline, so no request is taken.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted while output stalled");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_param) && $stable(last_out))
    else $error("stalled result changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind rmsprop_parameter_update_unit rpu_port_checks u_rpu_port_checks (.*);

>>> tb/rpu_checker.sv
// Checker for the RMSProp parameter update unit: predicts each result from
// the accepted requests and configuration writes. Depends on rpu_pkg.
`timescale 1ns / 1ps
module rpu_checker import rpu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     store_select,
  input  logic [IDX_W-1:0]         element_index,
  input  logic signed [DATA_W-1:0] param_value,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic                     last_in,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] new_param,
  input  logic                     last_out,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending_count
);

  typedef struct {
    logic signed [DATA_W-1:0] param;
    logic                     last;
  } update_t;

  logic [31:0] weight_sq [WEIGHT_COUNT];
  logic [31:0] bias_sq [BIAS_COUNT];
  logic [15:0] decay_r;
  logic [24:0] eps_r;
  logic [24:0] lr_r;
  logic [15:0] batch_r;
  update_t     expected_updates[$];

  // Integer square root, floor.
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Updates the square store and returns the new parameter.
  function automatic logic signed [DATA_W-1:0] rmsprop_update(
      logic sel, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] p,
      logic signed [DATA_W-1:0] g);
    logic [31:0]  old_sq;
    logic [63:0]  mag, gsq, d, q;
    logic [127:0] s, den;
    longint       res;
    if ((sel == 0 && idx >= WEIGHT_COUNT) || (sel == 1 && idx >= BIAS_COUNT)) return p;
    old_sq = sel ? bias_sq[idx] : weight_sq[idx];
    mag = g < 0 ? -64'(longint'(g)) : 64'(longint'(g));
    gsq = (mag * mag) >> 24;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    s = (128'(decay_r) * old_sq + 128'(65536 - decay_r) * gsq) >> 16;
    if (s > 128'hFFFF_FFFF) s = 128'hFFFF_FFFF;
    if (sel) bias_sq[idx] = s[31:0];
    else weight_sq[idx] = s[31:0];
    d = floor_sqrt((s[63:0] + eps_r) << 24);
    if (d == 0) d = 1;
    den = 128'(batch_r == 0 ? 16'd1 : batch_r) * d;
    q = 64'((128'(lr_r) * mag) / den);
    res = g < 0 ? longint'(p) + longint'(q) : longint'(p) - longint'(q);
    if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
    if (res < -64'sh8000_0000) res = -64'sh8000_0000;
    return res[31:0];
  endfunction

  assign pending_count = expected_updates.size();

  // Track configuration, predict on each accepted request, check results.
  always @(posedge clk) begin
    update_t exp_u;
    if (rst) begin
      foreach (weight_sq[i]) weight_sq[i] = 0;
      foreach (bias_sq[i]) bias_sq[i] = 0;
      decay_r = 16'd58982;
      eps_r = 25'd1;
      lr_r = 25'd16777;
      batch_r = 16'd1;
      fail_count = 0;
      expected_updates.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected result new_param=%0d", new_param);
          fail_count++;
        end else begin
          exp_u = expected_updates.pop_front();
          if (new_param !== exp_u.param) begin
            $error("new_param expected %0d actual %0d", exp_u.param, new_param);
            fail_count++;
          end
          if (last_out !== exp_u.last) begin
            $error("last_out expected %0d actual %0d", exp_u.last, last_out);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        exp_u.param = rmsprop_update(store_select, element_index, param_value, gradient);
        exp_u.last = last_in;
        expected_updates.push_back(exp_u);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_DECAY:         decay_r = cfg_data[15:0];
          CFG_EPSILON:       eps_r = cfg_data;
          CFG_LEARNING_RATE: lr_r = cfg_data;
          CFG_BATCH_SIZE:    batch_r = cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the RMSProp parameter update unit: drives requests,
// configuration and output stalls. Depends on rpu_pkg, the unit and rpu_checker.
`timescale 1ns / 1ps
module tb_top;
  import rpu_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     store_select;
  logic [IDX_W-1:0]         element_index;
  logic signed [DATA_W-1:0] param_value;
  logic signed [DATA_W-1:0] gradient;
  logic                     last_in;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] new_param;
  logic                     last_out;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  int                       fail_count;
  int                       pending_count;
  bit                       calm_phase;
  int                       request_total;

  rmsprop_parameter_update_unit i_dut (.*);

  rpu_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Output stalls in random bursts, none in the calm phase.
  initial begin
    int n;
    out_ready = 1;
    forever begin
      @(posedge clk);
      if (!calm_phase && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end
    end
  end

  // Valid stays up after acceptance until the next request or an idle gap
  // replaces it, so back-to-back requests go out without a gap.
  task automatic send_request(logic sel, logic [IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] g,
                              logic last);
    int n;
    cfg_valid <= 0;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    store_select <= sel;
    element_index <= idx;
    param_value <= p;
    gradient <= g;
    last_in <= last;
    do @(posedge clk); while (!in_ready);
    request_total++;
  endtask

  // The write valid is dropped by the next request.
  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait for the pipeline to drain, then past its latency.
  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3) == 0 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed(32'($urandom_range(0, 33554432))) - 32'sd16777216;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range indexes on a small working set so the stores build up.
  task automatic random_burst(int count);
    logic sel;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      sel = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: idx = IDX_W'($urandom);
        1, 2, 3: idx = sel ? IDX_W'($urandom_range(0, 255)) : IDX_W'($urandom_range(0, 4095));
        default: idx = IDX_W'($urandom_range(0, 15));
      endcase
      send_request(sel, idx, rand_value(), rand_value(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    calm_phase = 0;
    request_total = 0;
    rst = 1;
    in_valid = 0;
    store_select = 0;
    element_index = 0;
    param_value = 0;
    gradient = 0;
    last_in = 0;
    cfg_valid = 0;
    cfg_index = CFG_DECAY;
    cfg_data = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: field extremes and special cases at reset settings.
    send_request(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1);
    send_request(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_request(0, 4095, 32'sh0100_0000, 32'sh0100_0000, 1);
    send_request(1, 255, -32'sd5, -32'sd1, 0);
    send_request(1, 256, 32'sh1234_5678, 32'sh0100_0000, 1);
    send_request(1, 4095, -32'sd7, 32'sh8000_0000, 0);
    send_request(0, 7, 0, 0, 1);
    send_request(0, 7, 32'sh7FFF_FFF0, -32'sh7FFF_FFFF, 0);
    drain();

    // Zero epsilon with a zero square, zero batch size, full learning rate.
    write_reg(CFG_EPSILON, 0);
    write_reg(CFG_BATCH_SIZE, 0);
    write_reg(CFG_LEARNING_RATE, 25'd16777216);
    write_reg(CFG_DECAY, 25'h00FFFF);
    send_request(0, 100, 0, 0, 1);
    send_request(0, 100, 32'sh7FFF_0000, -32'sh7FFF_FFFF, 0);
    send_request(1, 100, 32'sh8000_0100, 32'sh7FFF_FFFF, 1);
    send_request(0, 101, 32'sd0, 32'sd1, 0);
    send_request(1, 3, 32'sd0, -32'sd1, 1);
    drain();

    write_reg(CFG_DECAY, 0);
    write_reg(CFG_EPSILON, 25'd16777216);
    write_reg(CFG_LEARNING_RATE, 0);
    write_reg(CFG_BATCH_SIZE, 25'h00FFFF);
    send_request(0, 5, 32'sh0100_0000, 32'sh7FFF_FFFF, 1);
    send_request(1, 5, 32'sh0100_0000, 32'sh8000_0000, 0);
    drain();

    // Random phases, each under a fresh configuration.
    repeat (5) begin
      write_reg(CFG_DECAY, $urandom_range(0, 3) == 0 ? 25'($urandom_range(0, 65535))
                                                    : 25'($urandom_range(52000, 65535)));
      write_reg(CFG_EPSILON, $urandom_range(0, 2) == 0 ? 25'($urandom_range(1, 16777216))
                                                      : 25'($urandom_range(1, 4096)));
      write_reg(CFG_LEARNING_RATE, 25'($urandom_range(0, 16777216)));
      write_reg(CFG_BATCH_SIZE, $urandom_range(0, 1) ? 25'($urandom_range(1, 8))
                                                    : 25'($urandom_range(1, 65535)));
      random_burst(200);
      drain();
    end

    // Last part with no idling on either side.
    calm_phase = 1;
    random_burst(230);
    drain();

    $display("Ran %0d requests over eight settings, incl. zero epsilon and batch,",
             request_total);
    $display("out-of-range indexes, saturation, and stalls on both channels.");
    if (fail_count == 0) begin
      $display("rmsprop_parameter_update_unit: match");
    end else begin
      $display("rmsprop_parameter_update_unit: mismatch");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #5ms;
    $display("rmsprop_parameter_update_unit: mismatch");
    $finish;
  end

endmodule
